// ----- src/bfdc_pkg.sv -----
// Shared types and codes for the backlight fade and dim controller.
`timescale 1ns / 1ps
package bfdc_pkg;

  typedef enum logic [2:0] {
    FUNC_UPDATE = 3'd0,
    FUNC_PREDIM = 3'd1,
    FUNC_OFF    = 3'd2,
    FUNC_ON     = 3'd3,
    FUNC_RESET  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    CFG_BRIGHTNESS    = 3'd0,
    CFG_SLEEP_TIMEOUT = 3'd1,
    CFG_DIM_LEAD      = 3'd2,
    CFG_DIM_END_FRAC  = 3'd3,
    CFG_PREDIM_FRAC   = 3'd4,
    CFG_MIN_DIM_DUTY  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_init;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } status_t;

endpackage

// ----- src/bfdc_ctrl.sv -----
// Sequencer for the backlight controller: accepts a beat, runs the datapath, posts the result.
`timescale 1ns / 1ps
module bfdc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bfdc_pkg::status_t status,
  output bfdc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd.load     = (state == ST_IDLE) && in_valid && in_ready;
    cmd.prep     = (state == ST_PREP);
    cmd.div_init = (state == ST_EVAL) && status.need_div;
    cmd.div_step = (state == ST_DIV);
    cmd.commit   = (state == ST_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ((state == ST_DONE) && slot_free) || (out_valid && !out_ready);
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_PREP;
            in_ready <= 1'b0;
          end
        end
        ST_PREP: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          state <= status.need_div ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (status.div_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            in_ready <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- src/bfdc_dp.sv -----
// Datapath: configuration, fade state, dim ramp arithmetic, serial scaler and result register.
`timescale 1ns / 1ps
module bfdc_dp #(
  parameter int TIME_BITS = 32,
  parameter int DUTY_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [TIME_BITS-1:0]  cfg_data,
  input  logic [2:0]            func,
  input  logic [TIME_BITS-1:0]  now_ms,
  input  logic [TIME_BITS-1:0]  last_activity_ms,
  input  logic                  in_dim_phase,
  input  bfdc_pkg::cmd_t        cmd,
  output bfdc_pkg::status_t     status,
  output logic [DUTY_BITS-1:0]  duty,
  output logic                  duty_written,
  output logic                  pwm_running,
  output logic                  backlight_cut
);

  localparam int XW = (DUTY_BITS > 8) ? DUTY_BITS : 8;
  localparam logic [XW-1:0] DMAX = XW'((64'd1 << DUTY_BITS) - 64'd1);

  logic [7:0]           brightness;
  logic [TIME_BITS-1:0] sleep_timeout_ms;
  logic [TIME_BITS-1:0] dim_lead_ms;
  logic [7:0]           dim_end_fraction_q8;
  logic [7:0]           predim_fraction_q8;
  logic [7:0]           min_dim_duty;

  logic [TIME_BITS-1:0] fade_start_ms;
  logic                 fade_started;
  logic                 pwm_active;
  logic                 screen_off;
  logic [DUTY_BITS-1:0] current_duty;

  logic [2:0]           func_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] last_q;
  logic                 dim_q;

  logic                 elapsed_lt;
  logic [7:0]           elapsed_lo;
  logic [7:0]           end_level;
  logic [7:0]           predim_level;
  logic [TIME_BITS-1:0] ramp_pos;

  logic [TIME_BITS-1:0] div_rem;
  logic [7:0]           div_quo;
  logic [7:0]           div_dd;
  logic [3:0]           div_cnt;

  logic [TIME_BITS-1:0] elapsed;
  logic [15:0]          end_prod;
  logic [15:0]          predim_prod;
  logic [TIME_BITS-1:0] add_b;
  logic [TIME_BITS:0]   add_s;
  logic                 add_c;
  logic [TIME_BITS:0]   add_r;

  logic [7:0]           ramp_level;
  logic [7:0]           dim_floor;
  logic [7:0]           predim_floor;

  logic [TIME_BITS-1:0] fade_start_next;
  logic                 fade_started_next;
  logic                 pwm_active_next;
  logic                 screen_off_next;
  logic [DUTY_BITS-1:0] current_duty_next;
  logic                 written_next;

  function automatic logic [DUTY_BITS-1:0] sat_duty(input logic [7:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    if (w > DMAX) begin
      w = DMAX;
    end
    return DUTY_BITS'(w);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness          <= 8'd180;
      sleep_timeout_ms    <= TIME_BITS'(30000);
      dim_lead_ms         <= TIME_BITS'(5000);
      dim_end_fraction_q8 <= 8'd31;
      predim_fraction_q8  <= 8'd77;
      min_dim_duty        <= 8'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        bfdc_pkg::CFG_BRIGHTNESS:    brightness          <= cfg_data[7:0];
        bfdc_pkg::CFG_SLEEP_TIMEOUT: sleep_timeout_ms    <= cfg_data;
        bfdc_pkg::CFG_DIM_LEAD:      dim_lead_ms         <= cfg_data;
        bfdc_pkg::CFG_DIM_END_FRAC:  dim_end_fraction_q8 <= cfg_data[7:0];
        bfdc_pkg::CFG_PREDIM_FRAC:   predim_fraction_q8  <= cfg_data[7:0];
        bfdc_pkg::CFG_MIN_DIM_DUTY:  min_dim_duty        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      now_q  <= now_ms;
      last_q <= last_activity_ms;
      dim_q  <= in_dim_phase;
    end
  end

  assign elapsed     = fade_started ? (now_q - fade_start_ms) : '0;
  assign end_prod    = brightness * dim_end_fraction_q8;
  assign predim_prod = brightness * predim_fraction_q8;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      elapsed_lt   <= elapsed < TIME_BITS'(brightness);
      elapsed_lo   <= elapsed[7:0];
      end_level    <= end_prod[15:8];
      predim_level <= predim_prod[15:8];
      ramp_pos     <= (now_q - last_q) - (sleep_timeout_ms - dim_lead_ms);
    end
  end

  always_comb begin
    status.need_div = (func_q == bfdc_pkg::FUNC_UPDATE) && !screen_off && !elapsed_lt &&
                      dim_q && (dim_lead_ms != '0) && (ramp_pos < dim_lead_ms) &&
                      (brightness > end_level);
    status.div_last = (div_cnt == 4'd15);
  end

  assign add_b = div_cnt[0] ? ramp_pos : div_rem;
  assign add_s = {1'b0, div_rem} + {1'b0, add_b};
  assign add_c = add_s >= {1'b0, dim_lead_ms};
  assign add_r = add_c ? (add_s - {1'b0, dim_lead_ms}) : add_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_rem <= '0;
      div_quo <= '0;
      div_dd  <= brightness - end_level;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 4'd1;
      if (!div_cnt[0]) begin
        div_rem <= add_r[TIME_BITS-1:0];
        div_quo <= {div_quo[6:0], add_c};
      end else begin
        if (div_dd[7]) begin
          div_rem <= add_r[TIME_BITS-1:0];
          div_quo <= div_quo + {7'd0, add_c};
        end
        div_dd <= {div_dd[6:0], 1'b0};
      end
    end
  end

  assign ramp_level   = status.need_div ? (brightness - div_quo) : end_level;
  assign dim_floor    = (ramp_level < min_dim_duty) ? min_dim_duty : ramp_level;
  assign predim_floor = (predim_level < min_dim_duty) ? min_dim_duty : predim_level;

  always_comb begin
    fade_start_next   = fade_start_ms;
    fade_started_next = fade_started;
    pwm_active_next   = pwm_active;
    screen_off_next   = screen_off;
    current_duty_next = current_duty;
    written_next      = 1'b0;
    case (func_q)
      bfdc_pkg::FUNC_UPDATE: begin
        if (!screen_off) begin
          if (!fade_started) begin
            fade_start_next   = now_q;
            fade_started_next = 1'b1;
          end
          if (elapsed_lt) begin
            pwm_active_next   = 1'b1;
            current_duty_next = sat_duty(elapsed_lo);
            written_next      = 1'b1;
          end else if (dim_q) begin
            pwm_active_next   = 1'b1;
            current_duty_next = sat_duty(dim_floor);
            written_next      = 1'b1;
          end else if (XW'(brightness) < DMAX) begin
            pwm_active_next   = 1'b1;
            current_duty_next = sat_duty(brightness);
            written_next      = 1'b1;
          end else begin
            pwm_active_next = 1'b0;
          end
        end
      end
      bfdc_pkg::FUNC_PREDIM: begin
        pwm_active_next   = 1'b1;
        current_duty_next = sat_duty(predim_floor);
        written_next      = 1'b1;
      end
      bfdc_pkg::FUNC_OFF: begin
        if (!screen_off) begin
          screen_off_next = 1'b1;
          pwm_active_next = 1'b0;
        end
      end
      bfdc_pkg::FUNC_ON: begin
        if (screen_off) begin
          screen_off_next   = 1'b0;
          pwm_active_next   = 1'b1;
          current_duty_next = sat_duty(brightness);
          written_next      = 1'b1;
        end
      end
      bfdc_pkg::FUNC_RESET: begin
        pwm_active_next   = 1'b0;
        fade_start_next   = '0;
        fade_started_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_start_ms <= '0;
      fade_started  <= 1'b0;
      pwm_active    <= 1'b1;
      screen_off    <= 1'b0;
      current_duty  <= '0;
    end else if (cmd.commit) begin
      fade_start_ms <= fade_start_next;
      fade_started  <= fade_started_next;
      pwm_active    <= pwm_active_next;
      screen_off    <= screen_off_next;
      current_duty  <= current_duty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      duty          <= current_duty_next;
      duty_written  <= written_next;
      pwm_running   <= pwm_active_next;
      backlight_cut <= screen_off_next;
    end
  end

endmodule

// ----- src/backlight_fade_dim_controller.sv -----
// Top level of the backlight PWM duty controller.
`timescale 1ns / 1ps
// Takes one tick or event beat at a time (update, pre-sleep dim, power off, power on,
// fade reset) and returns one result beat with the duty register, a duty-written flag,
// the PWM running flag and the backlight cut flag. After acceptance a beat passes the prep,
// evaluate and done states; an update tick inside the dim ramp also passes the divide
// state, where the ramp position is scaled by a restoring serial unit built on one
// add-and-reduce adder. The result is posted from the done state once the output register
// is free, and the next input beat can then be taken. The result sits in an output register, so a
// new beat is taken while the last one waits.
// Configuration writes are accepted every cycle and must only come while the block is idle.
module backlight_fade_dim_controller #(
  parameter int TIME_BITS = 32,
  parameter int DUTY_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [TIME_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           func,
  input  logic [TIME_BITS-1:0] now_ms,
  input  logic [TIME_BITS-1:0] last_activity_ms,
  input  logic                 in_dim_phase,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DUTY_BITS-1:0] duty,
  output logic                 duty_written,
  output logic                 pwm_running,
  output logic                 backlight_cut
);

  bfdc_pkg::cmd_t    cmd;
  bfdc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  bfdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bfdc_dp #(
    .TIME_BITS (TIME_BITS),
    .DUTY_BITS (DUTY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .func             (func),
    .now_ms           (now_ms),
    .last_activity_ms (last_activity_ms),
    .in_dim_phase     (in_dim_phase),
    .cmd              (cmd),
    .status           (status),
    .duty             (duty),
    .duty_written     (duty_written),
    .pwm_running      (pwm_running),
    .backlight_cut    (backlight_cut)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a beat is in flight");

  a_write_runs_pwm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && duty_written) |-> pwm_running)
    else $error("duty written without the PWM running");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result posted with no beat in flight");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the backlight fade and dim controller.
`timescale 1ns / 1ps
module tb;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam int PHASE_ITEMS = 425;

  typedef struct {
    logic [2:0]  f;
    logic [31:0] now;
    logic [31:0] last;
    logic        dim;
  } tick_t;

  typedef struct {
    logic [7:0] duty;
    logic       written;
    logic       pwm;
    logic       cut;
  } duty_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = '0;
  logic [31:0] now_ms = '0;
  logic [31:0] last_activity_ms = '0;
  logic        in_dim_phase = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  duty;
  logic        duty_written;
  logic        pwm_running;
  logic        backlight_cut;

  backlight_fade_dim_controller dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .now_ms           (now_ms),
    .last_activity_ms (last_activity_ms),
    .in_dim_phase     (in_dim_phase),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .duty             (duty),
    .duty_written     (duty_written),
    .pwm_running      (pwm_running),
    .backlight_cut    (backlight_cut)
  );

  always #4 clk = ~clk;

  // shadow registers
  logic [7:0]  brightness_r;
  logic [31:0] timeout_r;
  logic [31:0] lead_r;
  logic [7:0]  end_frac_r;
  logic [7:0]  predim_frac_r;
  logic [7:0]  min_dim_r;

  // shadow state
  logic [31:0] fade_start_q;
  logic        fade_on_q;
  logic        pwm_q;
  logic        cut_q;
  logic [7:0]  duty_q;

  tick_t      tick_pending_q[$];
  duty_beat_t duty_expect_q[$];
  tick_t      drv_tick;
  duty_beat_t got_beat;
  duty_beat_t exp_beat;
  int         n_sent = 0;
  int         n_checked = 0;
  int         errors = 0;
  int         idle_pct = 18;

  function automatic logic [7:0] q8_scale(input logic [7:0] b, input logic [7:0] frac);
    logic [15:0] prod;
    prod = b * frac;
    return prod[15:8];
  endfunction

  function automatic duty_beat_t predict_beat(input logic [2:0] f, input logic [31:0] now,
                                              input logic [31:0] last, input logic dim);
    duty_beat_t  r;
    logic [31:0] elapsed;
    logic [31:0] ramp_pos;
    logic [7:0]  end_level;
    logic [7:0]  level;
    logic [63:0] drop;
    logic        wr;
    wr = 1'b0;
    level = '0;
    case (f)
      bfdc_pkg::FUNC_UPDATE: begin
        if (!cut_q) begin
          if (!fade_on_q) begin
            fade_start_q = now;
            fade_on_q = 1'b1;
          end
          elapsed = now - fade_start_q;
          if (elapsed < {24'd0, brightness_r}) begin
            level = elapsed[7:0];
            wr = 1'b1;
          end else if (dim) begin
            ramp_pos = (now - last) - (timeout_r - lead_r);
            end_level = q8_scale(brightness_r, end_frac_r);
            if (lead_r != 0 && ramp_pos < lead_r && brightness_r > end_level) begin
              drop = ({56'd0, brightness_r - end_level} * {32'd0, ramp_pos}) / {32'd0, lead_r};
              level = brightness_r - drop[7:0];
            end else begin
              level = end_level;
            end
            if (level < min_dim_r) level = min_dim_r;
            wr = 1'b1;
          end else if (brightness_r != 8'hFF) begin
            level = brightness_r;
            wr = 1'b1;
          end else begin
            pwm_q = 1'b0;
          end
        end
      end
      bfdc_pkg::FUNC_PREDIM: begin
        level = q8_scale(brightness_r, predim_frac_r);
        if (level < min_dim_r) level = min_dim_r;
        wr = 1'b1;
      end
      bfdc_pkg::FUNC_OFF: begin
        if (!cut_q) begin
          cut_q = 1'b1;
          pwm_q = 1'b0;
        end
      end
      bfdc_pkg::FUNC_ON: begin
        if (cut_q) begin
          cut_q = 1'b0;
          level = brightness_r;
          wr = 1'b1;
        end
      end
      bfdc_pkg::FUNC_RESET: begin
        pwm_q = 1'b0;
        fade_start_q = '0;
        fade_on_q = 1'b0;
      end
      default: ;
    endcase
    if (wr) begin
      duty_q = level;
      pwm_q = 1'b1;
    end
    r.duty = duty_q;
    r.written = wr;
    r.pwm = pwm_q;
    r.cut = cut_q;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        duty_expect_q.push_back(predict_beat(func, now_ms, last_activity_ms, in_dim_phase));
      if (!in_valid || in_ready) begin
        if (tick_pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drv_tick = tick_pending_q.pop_front();
          func <= drv_tick.f;
          now_ms <= drv_tick.now;
          last_activity_ms <= drv_tick.last;
          in_dim_phase <= drv_tick.dim;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (duty_expect_q.size() == 0) begin
          $error("unexpected result beat: duty %0d", duty);
          errors++;
        end else begin
          exp_beat = duty_expect_q.pop_front();
          got_beat.duty = duty;
          got_beat.written = duty_written;
          got_beat.pwm = pwm_running;
          got_beat.cut = backlight_cut;
          if (got_beat.duty !== exp_beat.duty) begin
            $error("duty: expected %0d, got %0d", exp_beat.duty, got_beat.duty);
            errors++;
          end
          if (got_beat.written !== exp_beat.written) begin
            $error("duty_written: expected %0d, got %0d", exp_beat.written, got_beat.written);
            errors++;
          end
          if (got_beat.pwm !== exp_beat.pwm) begin
            $error("pwm_running: expected %0d, got %0d", exp_beat.pwm, got_beat.pwm);
            errors++;
          end
          if (got_beat.cut !== exp_beat.cut) begin
            $error("backlight_cut: expected %0d, got %0d", exp_beat.cut, got_beat.cut);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic push_tick(input logic [2:0] f, input logic [31:0] now,
                           input logic [31:0] last, input logic dim);
    tick_t t;
    t.f = f;
    t.now = now;
    t.last = last;
    t.dim = dim;
    tick_pending_q.push_back(t);
    n_sent++;
  endtask

  task automatic drain();
    while (n_checked != n_sent) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // hold valid across back-to-back beats; caller drops it after the last one
  task automatic cfg_beat(input bfdc_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bfdc_pkg::CFG_BRIGHTNESS:    brightness_r = val[7:0];
      bfdc_pkg::CFG_SLEEP_TIMEOUT: timeout_r = val;
      bfdc_pkg::CFG_DIM_LEAD:      lead_r = val;
      bfdc_pkg::CFG_DIM_END_FRAC:  end_frac_r = val[7:0];
      bfdc_pkg::CFG_PREDIM_FRAC:   predim_frac_r = val[7:0];
      bfdc_pkg::CFG_MIN_DIM_DUTY:  min_dim_r = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [7:0] b, input logic [31:0] tmo,
                              input logic [31:0] lead, input logic [7:0] endf,
                              input logic [7:0] pref, input logic [7:0] mind);
    cfg_beat(bfdc_pkg::CFG_BRIGHTNESS, {24'd0, b});
    cfg_beat(bfdc_pkg::CFG_SLEEP_TIMEOUT, tmo);
    cfg_beat(bfdc_pkg::CFG_DIM_LEAD, lead);
    cfg_beat(bfdc_pkg::CFG_DIM_END_FRAC, {24'd0, endf});
    cfg_beat(bfdc_pkg::CFG_PREDIM_FRAC, {24'd0, pref});
    cfg_beat(bfdc_pkg::CFG_MIN_DIM_DUTY, {24'd0, mind});
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_session();
    logic [31:0] t;
    logic [31:0] span;
    logic [31:0] e;
    span = timeout_r - lead_r;
    case ($urandom_range(5))
      0, 1: push_tick(bfdc_pkg::FUNC_RESET, $urandom, $urandom, 1'($urandom));
      2: begin
        push_tick(bfdc_pkg::FUNC_OFF, $urandom, $urandom, 1'($urandom));
        push_tick(bfdc_pkg::FUNC_UPDATE, $urandom, $urandom, 1'($urandom));
        push_tick(bfdc_pkg::FUNC_ON, $urandom, $urandom, 1'($urandom));
      end
      default: ;
    endcase
    t = $urandom;
    repeat ($urandom_range(6, 1)) begin
      push_tick(bfdc_pkg::FUNC_UPDATE, t, $urandom, 1'($urandom));
      t += $urandom_range(brightness_r / 4 + 1, 0);
    end
    t += brightness_r;
    repeat ($urandom_range(12, 3)) begin
      if (lead_r != 0 && $urandom_range(4) != 0) e = $urandom_range(lead_r - 1, 0);
      else e = lead_r + $urandom_range(300, 0);
      case ($urandom_range(9))
        0: push_tick(bfdc_pkg::FUNC_PREDIM, t, $urandom, 1'($urandom));
        1: push_tick(bfdc_pkg::FUNC_UPDATE, t, $urandom, 1'b0);
        2: push_tick(3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)), t, $urandom, 1'($urandom));
        default: push_tick(bfdc_pkg::FUNC_UPDATE, t, t - span - e, 1'b1);
      endcase
      t += $urandom_range(50, 0);
    end
  endtask

  task automatic random_phase();
    int target;
    target = n_sent + PHASE_ITEMS;
    while (n_sent < target) begin
      if ($urandom_range(4) == 0)
        push_tick(3'($urandom_range(7)), $urandom, $urandom, 1'($urandom));
      else
        queue_session();
    end
    drain();
  endtask

  initial begin
    brightness_r = 8'd180;
    timeout_r = 32'd30000;
    lead_r = 32'd5000;
    end_frac_r = 8'd31;
    predim_frac_r = 8'd77;
    min_dim_r = 8'd4;
    fade_start_q = '0;
    fade_on_q = 1'b0;
    pwm_q = 1'b1;
    cut_q = 1'b0;
    duty_q = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fade-in, hold, dim ramp edges and events at reset settings
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'd0, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'd179, 32'hFFFF_FFFF, 1'b0);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'd180, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF - 32'd25000, 1'b1);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'd40000, 32'd12500, 1'b1);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'd40000, 32'd0, 1'b1);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'h8000_0000, 32'h8000_0000 - 32'd29999, 1'b1);
    push_tick(bfdc_pkg::FUNC_PREDIM, 32'd0, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_OFF, 32'd0, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_OFF, 32'd0, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'd500, 32'd0, 1'b1);
    push_tick(bfdc_pkg::FUNC_PREDIM, 32'd0, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_ON, 32'd0, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_ON, 32'd0, 32'd0, 1'b0);
    push_tick(FUNC_SPARE_LO, 32'd0, 32'd0, 1'b1);
    push_tick(FUNC_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_tick(bfdc_pkg::FUNC_RESET, 32'd0, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'hFFFF_FFF0, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'h0000_0010, 32'd0, 1'b0);
    drain();

    // full brightness stops the PWM; widest ramp
    apply_config(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'd0);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'h0000_1000, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'h0000_2000, 32'd0, 1'b0);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'h0000_3000, 32'h8000_3000, 1'b1);
    push_tick(bfdc_pkg::FUNC_PREDIM, 32'd0, 32'd0, 1'b0);
    drain();

    // zero brightness and lead, floor at top
    apply_config(8'd0, 32'd0, 32'd0, 8'd0, 8'd0, 8'hFF);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'd77, 32'd5, 1'b1);
    push_tick(bfdc_pkg::FUNC_UPDATE, 32'd78, 32'd5, 1'b0);
    push_tick(bfdc_pkg::FUNC_PREDIM, 32'd0, 32'd0, 1'b0);
    drain();

    apply_config(8'($urandom), $urandom_range(60000, 0), $urandom_range(10000, 1),
                 8'($urandom), 8'($urandom), 8'($urandom_range(40, 0)));
    random_phase();

    idle_pct = 0;
    apply_config(8'($urandom), $urandom_range(60000, 0), $urandom_range(2000, 1),
                 8'($urandom), 8'($urandom), 8'($urandom_range(40, 0)));
    random_phase();
    idle_pct = 18;

    apply_config(8'($urandom), $urandom, $urandom, 8'($urandom), 8'($urandom),
                 8'($urandom));
    random_phase();

    apply_config(8'($urandom_range(255, 200)), $urandom_range(60000, 0),
                 $urandom_range(300, 1), 8'($urandom), 8'($urandom),
                 8'($urandom_range(40, 0)));
    random_phase();

    if (errors == 0 && duty_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
